// ===== sv/itp_pkg.sv =====
package itp_pkg;

    // Accumulator width; bits above it are lost on suffix scaling
    localparam int VALUE_WIDTH = 32;
    // Width of the magnitude and value result fields
    localparam int OUT_W = 32;

    // Parse phases
    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_TRAIL  = 3'd4;

    // Radix codes
    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_HEX = 2'd1;
    localparam logic [1:0] RX_BIN = 2'd2;
    localparam logic [1:0] RX_OCT = 2'd3;

    // End-of-string character
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef struct packed {
        logic [2:0]             phase;
        logic [1:0]             radix;
        logic [VALUE_WIDTH-1:0] acc;
        logic                   minus;
        logic                   fault;
    } itp_state_t;

    typedef struct packed {
        logic [OUT_W-1:0] magnitude;
        logic [OUT_W-1:0] value;
        logic             negative;
        logic             fits_signed;
        logic             error;
    } itp_result_t;

    localparam itp_state_t STATE_INIT = '{
        phase: PH_LEAD,
        radix: RX_DEC,
        acc:   '0,
        minus: 1'b0,
        fault: 1'b0
    };

endpackage

// ===== sv/itp_step.sv =====
module itp_step (
    input  logic [7:0]          ch,
    input  itp_pkg::itp_state_t cur,
    output itp_pkg::itp_state_t nxt,
    output itp_pkg::itp_result_t res
);

    localparam int W = itp_pkg::VALUE_WIDTH;

    // Map a character to its digit value, 16 for a non-digit
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= "0" && c <= "9")
            d = 5'(c - "0");
        else if (c >= "a" && c <= "f")
            d = 5'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F")
            d = 5'(c - "A" + 8'd10);
        return d;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == " ") || (c == 8'h09);
    endfunction

    // Fold letters to lower case (exact for letters only)
    function automatic logic [7:0] lower(input logic [7:0] c);
        return c | 8'h20;
    endfunction

    // Handle a character in the digits part: digit, suffix or end of digits
    function automatic itp_pkg::itp_state_t digit_step(input logic [7:0] c,
                                                       input itp_pkg::itp_state_t s);
        itp_pkg::itp_state_t r;
        logic [4:0]          d;
        logic [4:0]          base;
        logic [W+3:0]        ext;
        logic [W+3:0]        prod;
        logic [4:0]          sh;
        logic                bad;
        r       = s;
        r.phase = itp_pkg::PH_DIGITS;
        d       = digit_value(c);
        ext     = (W+4)'(s.acc);
        sh      = 5'd0;
        bad     = 1'b0;
        case (s.radix)
            itp_pkg::RX_HEX: begin base = 5'd16; prod = ext << 4; end
            itp_pkg::RX_BIN: begin base = 5'd2;  prod = ext << 1; end
            itp_pkg::RX_OCT: begin base = 5'd8;  prod = ext << 3; end
            default:         begin base = 5'd10; prod = (ext << 3) + (ext << 1); end
        endcase
        prod = prod + (W+4)'(d);
        if (d != 5'd16) begin
            // Reject a digit out of base or one that overflows the accumulator
            if (d >= base || (|prod[W+3:W]))
                r.fault = 1'b1;
            else
                r.acc = prod[W-1:0];
        end else begin
            if (lower(c) == "k")
                sh = 5'd10;
            else if (lower(c) == "m")
                sh = 5'd20;
            else if (lower(c) == "g")
                sh = 5'd30;
            else if (!is_blank(c))
                bad = 1'b1;
            if (bad) begin
                r.fault = 1'b1;
            end else begin
                r.acc   = s.acc << sh;
                r.phase = itp_pkg::PH_TRAIL;
            end
        end
        return r;
    endfunction

    logic [W-1:0] mag;
    logic [W-1:0] neg_mag;

    // Advance the parse state by one character
    always_comb
    begin
        nxt = cur;
        if (ch == itp_pkg::CH_NUL) begin
            nxt = itp_pkg::STATE_INIT;
        end else if (!cur.fault) begin
            unique case (cur.phase)
                itp_pkg::PH_LEAD:
                begin
                    if (is_blank(ch)) begin
                        nxt = cur;
                    end else if (ch == "-" || ch == "+") begin
                        nxt.minus = (ch == "-");
                        nxt.phase = itp_pkg::PH_SIGNED;
                    end else if (ch == "0") begin
                        nxt.phase = itp_pkg::PH_ZERO;
                    end else begin
                        nxt = digit_step(ch, cur);
                    end
                end
                itp_pkg::PH_SIGNED:
                begin
                    if (ch == "0")
                        nxt.phase = itp_pkg::PH_ZERO;
                    else
                        nxt = digit_step(ch, cur);
                end
                itp_pkg::PH_ZERO:
                begin
                    nxt.phase = itp_pkg::PH_DIGITS;
                    if (lower(ch) == "x") begin
                        nxt.radix = itp_pkg::RX_HEX;
                    end else if (lower(ch) == "b") begin
                        nxt.radix = itp_pkg::RX_BIN;
                    end else if (lower(ch) == "o") begin
                        nxt.radix = itp_pkg::RX_OCT;
                    end else if (lower(ch) == "d") begin
                        nxt.radix = itp_pkg::RX_DEC;
                    end else begin
                        // Leading zero was a plain decimal digit
                        nxt.radix = itp_pkg::RX_DEC;
                        nxt.acc   = '0;
                        nxt       = digit_step(ch, nxt);
                    end
                end
                itp_pkg::PH_DIGITS:
                begin
                    nxt = digit_step(ch, cur);
                end
                default:
                begin
                    if (!is_blank(ch))
                        nxt.fault = 1'b1;
                end
            endcase
        end
    end

    // Form the result from the state reached before the terminator
    assign mag     = cur.acc;
    assign neg_mag = W'(0) - mag;

    always_comb
    begin
        if (cur.fault) begin
            res             = '0;
            res.error       = 1'b1;
        end else begin
            res.magnitude   = itp_pkg::OUT_W'(mag);
            res.value       = itp_pkg::OUT_W'(cur.minus ? neg_mag : mag);
            res.negative    = cur.minus;
            res.fits_signed = !mag[W-1];
            res.error       = 1'b0;
        end
    end

endmodule

// ===== sv/integer_text_parser.sv =====
// Streaming text-to-integer parser.
// Input channel: one character per transaction on ch (ch_valid/ch_ready).
// A string is leading blanks, optional sign, optional 0x/0b/0o/0d prefix,
// digits, optional k/m/g suffix and trailing blanks; a NUL ends it.
// Output channel: one transaction per NUL (res_valid/res_ready) carrying
// magnitude, value, negative, fits_signed and error. Other characters
// produce no transaction.
// A NUL passes from the input register to the output register, raising res_valid.
// Throughput: one character per cycle unless a NUL waits on a full output
// register; every character takes one pass through the parse-step logic
// between the input register and the state and result registers.
// Stalls: a waiting result holds in the output register while non-NUL
// characters keep flowing; a NUL waits in the input register until the
// output register is free, and ch_ready drops only then.
// Reset: rst_n (asynchronous, active low) empties both registers and
// returns the parser to the leading-blank phase, decimal, zero.
module integer_text_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [7:0]               ch,
    input  logic                     ch_valid,
    output logic                     ch_ready,
    output logic [itp_pkg::OUT_W-1:0] magnitude,
    output logic [itp_pkg::OUT_W-1:0] value,
    output logic                     negative,
    output logic                     fits_signed,
    output logic                     error,
    output logic                     res_valid,
    input  logic                     res_ready
);

    logic                 s1_valid_reg;
    logic [7:0]           s1_ch_reg;
    itp_pkg::itp_state_t  state_reg;
    itp_pkg::itp_state_t  state_next;
    itp_pkg::itp_result_t step_res;
    itp_pkg::itp_result_t res_reg;
    logic                 res_valid_reg;
    logic                 out_free;
    logic                 s1_fire;
    logic                 s1_nul;

    itp_step u_step (
        .ch  (s1_ch_reg),
        .cur (state_reg),
        .nxt (state_next),
        .res (step_res)
    );

    // Advance the input stage unless a terminator meets a full output register
    assign s1_nul   = (s1_ch_reg == itp_pkg::CH_NUL);
    assign out_free = !res_valid_reg || res_ready;
    assign s1_fire  = s1_valid_reg && (!s1_nul || out_free);
    assign ch_ready = !s1_valid_reg || s1_fire;

    // Hold the input stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (ch_ready)
            s1_valid_reg <= ch_valid;
    end

    // Capture the character
    always_ff @(posedge clk)
    begin
        if (ch_valid && ch_ready)
            s1_ch_reg <= ch;
    end

    // Update the parse state once per processed character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= itp_pkg::STATE_INIT;
        else if (s1_fire)
            state_reg <= state_next;
    end

    // Load the result on a terminator, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (s1_fire && s1_nul)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_nul)
            res_reg <= step_res;
    end

    assign res_valid   = res_valid_reg;
    assign magnitude   = res_reg.magnitude;
    assign value       = res_reg.value;
    assign negative    = res_reg.negative;
    assign fits_signed = res_reg.fits_signed;
    assign error       = res_reg.error;

    // An error result carries no number
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && error |-> magnitude == '0 && value == '0 && !negative && !fits_signed)
        else $error("error result with nonzero fields");

    // A positive result has value equal to magnitude
    a_pos_value: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !error && !negative |-> value == magnitude)
        else $error("positive value differs from magnitude");

    // A terminator returns the parser to its initial state
    a_nul_resets: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_nul |=> state_reg.phase == itp_pkg::PH_LEAD && state_reg.acc == '0
            && !state_reg.fault && !state_reg.minus && state_reg.radix == itp_pkg::RX_DEC)
        else $error("parser state not cleared after terminator");

    // A non-terminator never creates a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !s1_nul |=> res_valid_reg == $past(res_valid_reg && !res_ready))
        else $error("result created by non-terminator");

    // Backpressure only when both registers are occupied
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !ch_ready |-> s1_valid_reg && res_valid_reg && s1_nul)
        else $error("input stalled without cause");

endmodule
